@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TSTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSTP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tstp_pkg.sv @@
package tstp_pkg;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

    localparam int SMALL_W = 7;
    localparam int MONTH_W = 8;
    localparam int YEAR_W  = 14;
    localparam int ACC_W   = 14;
    localparam int SLOTS   = 5;

    localparam logic [2:0] TOKEN_YEAR     = 3'd2;
    localparam logic [2:0] TOKEN_LAST     = 3'd5;
    localparam logic [2:0] TOKEN_COUNT    = 3'd6;
    localparam logic [2:0] LEN_YEAR       = 3'd4;
    localparam logic [2:0] LEN_SMALL      = 3'd2;
    localparam logic [2:0] LEN_CONVERT    = 3'd4;
    localparam logic [2:0] LEN_SATURATE   = 3'd5;

    localparam logic [YEAR_W-1:0] YEAR_BASE = 14'd1900;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

endpackage

@@ hdl/timestamp_text_parser.sv @@
// Channel  Direction  tdata                 tuser      tlast
// s        in         [7:0] character       -          is_end
// m        out        [49:0] date and time  valid_res  -
//
// A byte transfer updates the token state in the cycle it is taken and gives
// no result. A terminator transfer gives one result in the next cycle.
// One transfer per cycle is taken; the only stall comes from a held result
// register while the m side is not ready. Reset is synchronous and clears
// all parser state and the result valid flag; the result data and tuser are not reset.
module timestamp_text_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tstp_pkg::IN_DATA_W-1:0]    i_s_tdata,   // [7:0] character
    input  logic                              i_s_tlast,   // is_end
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [6:0] day_of_month, [14:7] month_index, [28:15] years_since_1900,
    // [35:29] hour_value, [42:36] minute_value, [49:43] second_value
    output logic [tstp_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser    // valid_res
);
    import tstp_pkg::*;

    logic [2:0]          r_tn, n_tn;
    logic [2:0]          r_len, n_len;
    t_phase              r_phase, n_phase;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_failed, n_failed;
    logic [SMALL_W-1:0]  r_small [SLOTS];
    logic [SMALL_W-1:0]  n_small [SLOTS];
    logic [YEAR_W-1:0]   r_year, n_year;

    logic                r_out_valid, n_out_valid;
    logic                r_out_user, n_out_user;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                w_take;
    logic                w_delim;
    logic                w_ws;
    logic                w_digit;
    logic                w_plus;
    logic [ACC_W-1:0]    w_acc_next;
    logic [2:0]          w_need;
    logic [2:0]          w_slot;
    logic                w_ok;
    logic [MONTH_W-1:0]  w_month;
    logic [YEAR_W-1:0]   w_year;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_take     = i_s_tvalid && o_s_tready;

    assign w_delim = (i_s_tdata == CH_MINUS) || (i_s_tdata == CH_SPACE)
                   || (i_s_tdata == CH_COLON);
    assign w_ws    = (i_s_tdata >= CH_TAB) && (i_s_tdata <= CH_CR);
    assign w_digit = (i_s_tdata >= CH_ZERO) && (i_s_tdata <= CH_NINE);
    assign w_plus  = (i_s_tdata == CH_PLUS);

    assign w_acc_next = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                      + {{(ACC_W-4){1'b0}}, i_s_tdata[3:0]};

    assign w_need = (r_tn == TOKEN_YEAR) ? LEN_YEAR : LEN_SMALL;
    assign w_slot = (r_tn < TOKEN_YEAR) ? r_tn : r_tn - 3'd1;

    // The terminator closes the sixth token, which is still in the accumulator.
    assign w_ok    = !r_failed && (r_tn == TOKEN_LAST) && (r_len == LEN_SMALL);
    assign w_month = {1'b0, r_small[1]} - 8'd1;
    assign w_year  = r_year - YEAR_BASE;

    always_comb begin
        n_tn     = r_tn;
        n_len    = r_len;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_failed = r_failed;
        n_small  = r_small;
        n_year   = r_year;
        if (w_take) begin
            if (i_s_tlast) begin
                n_tn     = '0;
                n_len    = '0;
                n_phase  = PH_SKIP;
                n_acc    = '0;
                n_failed = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    n_small[i] = '0;
                end
                n_year   = '0;
            end else if (!r_failed) begin
                if (w_delim) begin
                    if ((r_tn >= TOKEN_COUNT) || (r_len != w_need)) begin
                        n_failed = 1'b1;
                    end else begin
                        if (r_tn == TOKEN_YEAR) begin
                            n_year = r_acc;
                        end else begin
                            n_small[w_slot] = r_acc[SMALL_W-1:0];
                        end
                        n_tn    = r_tn + 3'd1;
                        n_len   = '0;
                        n_phase = PH_SKIP;
                        n_acc   = '0;
                    end
                end else begin
                    if (r_len < LEN_CONVERT) begin
                        case (r_phase)
                            PH_SKIP: begin
                                if (w_ws) begin
                                    n_phase = PH_SKIP;
                                end else if (w_plus) begin
                                    n_phase = PH_DIGITS;
                                end else if (w_digit) begin
                                    n_acc   = w_acc_next;
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_DIGITS: begin
                                if (w_digit) begin
                                    n_acc = w_acc_next;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                    if (r_len < LEN_SATURATE) begin
                        n_len = r_len + 3'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        if (w_take && i_s_tlast) begin
            n_out_valid = 1'b1;
            n_out_user  = w_ok;
            n_out_data  = '0;
            if (w_ok) begin
                n_out_data = {6'b0, r_acc[SMALL_W-1:0], r_small[3], r_small[2],
                              w_year, w_month, r_small[0]};
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tn        <= '0;
            r_len       <= '0;
            r_phase     <= PH_SKIP;
            r_acc       <= '0;
            r_failed    <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_small[i] <= '0;
            end
            r_year      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_tn        <= n_tn;
            r_len       <= n_len;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_failed    <= n_failed;
            r_small     <= n_small;
            r_year      <= n_year;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = r_out_data;

endmodule

@@ hdl/tstp_checker.sv @@
module tstp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic [tstp_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                              i_s_tlast,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [tstp_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input  logic                              o_m_tuser
);
    import tstp_pkg::*;
    `include "assert_macros.svh"

    logic w_in_xfer;
    logic w_held;

    assign w_in_xfer = i_s_tvalid && o_s_tready;
    assign w_held    = o_m_tvalid && !i_m_tready;

    `TSTP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
    `TSTP_ASSERT(a_hold, i_clk, i_rst_n, w_held |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "held result changed")
    `TSTP_ASSERT(a_end_gives_result, i_clk, i_rst_n, w_in_xfer && i_s_tlast |=> o_m_tvalid, "terminator transfer gave no result")
    `TSTP_ASSERT(a_result_has_cause, i_clk, i_rst_n, o_m_tvalid && !$past(w_held) |-> $past(w_in_xfer && i_s_tlast), "result without terminator")
    `TSTP_ASSERT(a_invalid_is_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0, "failed result carries data")

endmodule

bind timestamp_text_parser tstp_checker u_tstp_checker (.*);

@@ test/tb_timestamp_text_parser.sv @@
module tb_timestamp_text_parser;
    import tstp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        bit        ok;
        bit [6:0]  day;
        bit [7:0]  month;
        bit [13:0] year;
        bit [6:0]  hour;
        bit [6:0]  minute;
        bit [6:0]  second;
    } t_stamp;

    // Predicts the parse result of each terminated string and checks the results.
    class stamp_checker;
        t_stamp         expected_stamps[$];
        int             mismatches;
        bit [2:0]       tok_count;
        bit [2:0]       tok_len;
        t_phase         conv_phase;
        bit [ACC_W-1:0] acc;
        bit             failed;
        bit [6:0]       small_slot[SLOTS];
        bit [13:0]      year_raw;

        function new();
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_token();
            tok_len = 0;
            conv_phase = PH_SKIP;
            acc = 0;
        endfunction

        function void clear_string();
            tok_count = 0;
            failed = 1'b0;
            clear_token();
            foreach (small_slot[i]) small_slot[i] = 0;
            year_raw = 0;
        endfunction

        function void close_token();
            bit [2:0] need;
            if (tok_count >= TOKEN_COUNT) begin
                failed = 1'b1;
                return;
            end
            need = (tok_count == TOKEN_YEAR) ? LEN_YEAR : LEN_SMALL;
            if (tok_len != need) begin
                failed = 1'b1;
                return;
            end
            if (tok_count == TOKEN_YEAR) begin
                year_raw = acc;
            end else if (tok_count < TOKEN_YEAR) begin
                small_slot[tok_count] = acc[6:0];
            end else begin
                small_slot[tok_count - 1] = acc[6:0];
            end
            tok_count++;
            clear_token();
        endfunction

        function void take_byte(bit [7:0] ch);
            bit digit;
            digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            if (tok_len < LEN_CONVERT) begin
                if (conv_phase == PH_SKIP) begin
                    if (!(ch >= CH_TAB && ch <= CH_CR)) begin
                        if (ch == CH_PLUS) begin
                            conv_phase = PH_DIGITS;
                        end else if (digit) begin
                            acc = acc * 14'd10 + 14'(ch - CH_ZERO);
                            conv_phase = PH_DIGITS;
                        end else begin
                            conv_phase = PH_DONE;
                        end
                    end
                end else if (conv_phase == PH_DIGITS) begin
                    if (digit) begin
                        acc = acc * 14'd10 + 14'(ch - CH_ZERO);
                    end else begin
                        conv_phase = PH_DONE;
                    end
                end
            end
            if (tok_len < LEN_SATURATE) tok_len++;
        endfunction

        function void note_input(bit [7:0] ch, bit last);
            t_stamp s;
            if (!last) begin
                if (!failed) begin
                    if (ch == CH_MINUS || ch == CH_SPACE || ch == CH_COLON) begin
                        close_token();
                    end else begin
                        take_byte(ch);
                    end
                end
                return;
            end
            if (!failed) close_token();
            s = '{default: 0};
            s.ok = !failed && (tok_count == TOKEN_COUNT);
            if (s.ok) begin
                s.day    = small_slot[0];
                s.month  = {1'b0, small_slot[1]} - 8'd1;
                s.year   = year_raw - YEAR_BASE;
                s.hour   = small_slot[2];
                s.minute = small_slot[3];
                s.second = small_slot[4];
            end
            expected_stamps.push_back(s);
            clear_string();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void compare(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                report($sformatf("%s: expected %0d, got %0d", name, exp, act));
            end
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] d, bit ok);
            t_stamp e;
            if (expected_stamps.size() == 0) begin
                report($sformatf("result with none expected: tdata %h tuser %0b", d, ok));
                return;
            end
            e = expected_stamps.pop_front();
            compare("valid_res", e.ok, ok);
            compare("day_of_month", e.day, d[6:0]);
            compare("month_index", e.month, d[14:7]);
            compare("years_since_1900", e.year, d[28:15]);
            compare("hour_value", e.hour, d[35:29]);
            compare("minute_value", e.minute, d[42:36]);
            compare("second_value", e.second, d[49:43]);
            compare("tdata padding", 0, d[OUT_DATA_W-1:50]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    stamp_checker stamps = new();
    int src_idle_pct = 19;
    int sink_idle_pct = 75;
    int sent_items = 0;
    int cycles = 0;

    timestamp_text_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) stamps.note_input(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) stamps.check_result(o_m_tdata, o_m_tuser);
        end
    end

    task automatic send_byte(bit [7:0] ch, bit last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_items++;
    endtask

    // The byte carried by the terminator transfer is random, since it is ignored.
    task automatic send_string(bit [7:0] text[$]);
        foreach (text[i]) send_byte(text[i], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        bit [7:0] text[$];
        foreach (s[i]) text.push_back(s[i]);
        send_string(text);
    endtask

    function automatic bit [7:0] pick_delim();
        case ($urandom_range(0, 2))
            0: return CH_MINUS;
            1: return CH_SPACE;
            default: return CH_COLON;
        endcase
    endfunction

    // Mostly digits, with whitespace, plus signs and stray bytes mixed in.
    function automatic bit [7:0] token_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 78) return CH_TAB + 8'($urandom_range(0, 4));
        if (r < 84) return CH_PLUS;
        if (r < 88) return 8'h00;
        if (r < 90) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_stamp();
        int lens[7];
        int ntok;
        int kind;
        bit [7:0] text[$];
        lens = '{2, 2, 4, 2, 2, 2, 2};
        ntok = 6;
        kind = $urandom_range(0, 9);
        if (kind == 7) lens[$urandom_range(0, 5)] = $urandom_range(0, 6);
        if (kind == 8) ntok = $urandom_range(0, 7);
        if (kind == 9) begin
            repeat ($urandom_range(0, 24)) begin
                text.push_back(($urandom_range(0, 3) == 0) ? pick_delim()
                                                           : 8'($urandom_range(0, 255)));
            end
        end else begin
            for (int t = 0; t < ntok; t++) begin
                repeat (lens[t]) text.push_back(token_byte());
                if (t < ntok - 1) text.push_back(pick_delim());
            end
        end
        send_string(text);
    endtask

    initial begin
        int start;
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty string, largest values with month zero, then bytes zero and 255.
        send_text("");
        send_text("99-00-9999 99:99:99");
        send_string('{8'h00, 8'hFF});

        for (int p = 0; p < 3; p++) begin
            src_idle_pct  = (p == 0) ? 19 : (p == 1) ? 75 : 0;
            sink_idle_pct = (p == 0) ? 75 : (p == 1) ? 19 : 0;
            start = sent_items;
            while (sent_items - start < 160) begin
                send_random_stamp();
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (stamps.expected_stamps.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (stamps.mismatches == 0 && stamps.expected_stamps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
